// ===== rtl/shfp_pkg.sv =====
// ----------------------------------------------------------------------------
// shfp_pkg
// types and constants shared by the sync header frame parser modules
// ----------------------------------------------------------------------------
package shfp_pkg;

    localparam logic [7:0]  SYNC_FIRST     = 8'h40;  // '@'
    localparam logic [7:0]  SYNC_SECOND    = 8'h54;  // 'T'
    localparam logic [7:0]  SERIAL_MOD     = 8'h80;
    localparam logic [11:0] MAX_PAYLOAD    = 12'd2048;

    localparam logic [15:0] MIN_VER_RESET  = 16'd1;
    localparam logic [11:0] LIMIT_RESET    = 12'd2048;

    // register index taken from the apb address
    localparam logic REG_MIN_VER = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_REARM = 1'b1;

    typedef enum logic [15:0] {
        ST_SYNC1   = 16'h0001,
        ST_SYNC2   = 16'h0002,
        ST_SND_LO  = 16'h0004,
        ST_SND_HI  = 16'h0008,
        ST_LEN_LO  = 16'h0010,
        ST_LEN_HI  = 16'h0020,
        ST_SERIAL  = 16'h0040,
        ST_FEAT_LO = 16'h0080,
        ST_FEAT_HI = 16'h0100,
        ST_CMD     = 16'h0200,
        ST_MODE    = 16'h0400,
        ST_DATA    = 16'h0800,
        ST_CRC0    = 16'h1000,
        ST_CRC1    = 16'h2000,
        ST_CRC2    = 16'h4000,
        ST_CRC3    = 16'h8000
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [10:0] payload_index;
        logic [15:0] sender_id;
        logic [11:0] length_field;
        logic [7:0]  frame_serial;
        logic [15:0] feature_address;
        logic [7:0]  command_code;
        logic [7:0]  mode_byte;
        logic [31:0] checksum_value;
        logic        version_too_old;
        logic        lost_packets;
    } t_result;

endpackage

// ===== rtl/sync_header_frame_parser_top.sv =====
// result path: a result is registered in the output buffer once its byte is
//   accepted, and sits in the skid entry while an earlier result still waits
// throughput: one byte per cycle; a two-entry output buffer keeps input open
//   while one result waits, input stalls only when both entries are full
// reset: synchronous active low; parser returns to sync hunt, serial check is
//   skipped on the first frame, registers return to min version 1, limit 2048
// ----------------------------------------------------------------------------
// sync_header_frame_parser_top
// apb register file, frame parser and result buffer
// ----------------------------------------------------------------------------
module sync_header_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [10:0] o_payload_index,
    output logic [15:0] o_sender_id,
    output logic [11:0] o_length_field,
    output logic [7:0]  o_frame_serial,
    output logic [15:0] o_feature_address,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_mode_byte,
    output logic [31:0] o_checksum_value,
    output logic        o_version_too_old,
    output logic        o_lost_packets,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import shfp_pkg::*;

    logic [15:0] r_min_ver;
    logic [11:0] r_limit;
    logic        cfg_wr;
    logic        step;
    logic        res_valid;
    t_result     res;
    t_result     out_res;
    logic        space;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ver <= MIN_VER_RESET;
            r_limit   <= LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MIN_VER: r_min_ver <= pwdata[15:0];
                REG_LIMIT:   r_limit   <= pwdata[11:0];
                default:     r_limit   <= r_limit;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_VER: prdata = {16'd0, r_min_ver};
            REG_LIMIT:   prdata = {20'd0, r_limit};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_in_ready = space;
    assign step       = i_in_valid && space;

    shfp_parser u_parser (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_step               (step),
        .i_cmd                (i_cmd),
        .i_rx_byte            (i_rx_byte),
        .i_min_sender_version (r_min_ver),
        .i_payload_limit      (r_limit),
        .o_res_valid          (res_valid),
        .o_res                (res)
    );

    shfp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_res)
    );

    assign o_kind            = out_res.kind;
    assign o_payload_byte    = out_res.payload_byte;
    assign o_payload_index   = out_res.payload_index;
    assign o_sender_id       = out_res.sender_id;
    assign o_length_field    = out_res.length_field;
    assign o_frame_serial    = out_res.frame_serial;
    assign o_feature_address = out_res.feature_address;
    assign o_command_code    = out_res.command_code;
    assign o_mode_byte       = out_res.mode_byte;
    assign o_checksum_value  = out_res.checksum_value;
    assign o_version_too_old = out_res.version_too_old;
    assign o_lost_packets    = out_res.lost_packets;

endmodule

// ===== rtl/shfp_parser.sv =====
// ----------------------------------------------------------------------------
// shfp_parser
// byte-wide frame parser: sync hunt, header capture, payload and checksum
// ----------------------------------------------------------------------------
module shfp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_cmd,
    input  logic [7:0]        i_rx_byte,
    input  logic [15:0]       i_min_sender_version,
    input  logic [11:0]       i_payload_limit,
    output logic              o_res_valid,
    output shfp_pkg::t_result o_res
);
    import shfp_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [15:0] r_sender,   n_sender;
    logic [11:0] r_length,   n_length;
    logic [7:0]  r_serial,   n_serial;
    logic [15:0] r_feature,  n_feature;
    logic [7:0]  r_command,  n_command;
    logic [7:0]  r_mode,     n_mode;
    logic [10:0] r_data_pos, n_data_pos;
    logic [31:0] r_checksum, n_checksum;
    logic [1:0]  r_flags,    n_flags;
    logic [7:0]  r_prev_ser, n_prev_ser;
    logic        r_first,    n_first;

    logic [15:0] full_len;
    logic [11:0] limit;
    logic [7:0]  expect_ser;
    logic [11:0] pos_plus;
    logic        res_done;
    logic [7:0]  res_byte;
    logic [10:0] res_index;

    assign full_len   = {i_rx_byte, r_length[7:0]};
    assign limit      = (i_payload_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : i_payload_limit;
    assign expect_ser = (r_prev_ser + 8'd1) & (SERIAL_MOD - 8'd1);
    assign pos_plus   = {1'b0, r_data_pos} + 12'd1;

    always_comb begin
        n_phase     = r_phase;
        n_sender    = r_sender;
        n_length    = r_length;
        n_serial    = r_serial;
        n_feature   = r_feature;
        n_command   = r_command;
        n_mode      = r_mode;
        n_data_pos  = r_data_pos;
        n_checksum  = r_checksum;
        n_flags     = r_flags;
        n_prev_ser  = r_prev_ser;
        n_first     = r_first;
        o_res_valid = 1'b0;
        res_done    = 1'b0;
        res_byte    = 8'd0;
        res_index   = 11'd0;
        if (i_step && i_cmd == CMD_REARM) begin
            n_first = 1'b1;
        end else if (i_step) begin
            unique case (r_phase)
                ST_SYNC1: begin
                    n_flags = 2'b00;
                    if (i_rx_byte == SYNC_FIRST) begin
                        n_phase = ST_SYNC2;
                    end
                end
                ST_SYNC2: begin
                    n_phase = (i_rx_byte == SYNC_SECOND) ? ST_SND_LO : ST_SYNC1;
                end
                ST_SND_LO: begin
                    n_sender = {8'd0, i_rx_byte};
                    n_phase  = ST_SND_HI;
                end
                ST_SND_HI: begin
                    n_sender = {i_rx_byte, r_sender[7:0]};
                    if (n_sender < i_min_sender_version) begin
                        n_flags[0] = 1'b1;
                    end
                    n_phase = ST_LEN_LO;
                end
                ST_LEN_LO: begin
                    n_length = {4'd0, i_rx_byte};
                    n_phase  = ST_LEN_HI;
                end
                ST_LEN_HI: begin
                    if (full_len > {4'd0, limit}) begin
                        n_phase = ST_SYNC1;
                    end else begin
                        n_length = full_len[11:0];
                        n_phase  = ST_SERIAL;
                    end
                end
                ST_SERIAL: begin
                    n_serial = i_rx_byte;
                    if (r_first) begin
                        n_first = 1'b0;
                    end else if (i_rx_byte != expect_ser) begin
                        n_flags[1] = 1'b1;
                    end
                    n_prev_ser = i_rx_byte;
                    n_phase    = ST_FEAT_LO;
                end
                ST_FEAT_LO: begin
                    n_feature = {8'd0, i_rx_byte};
                    n_phase   = ST_FEAT_HI;
                end
                ST_FEAT_HI: begin
                    n_feature = {i_rx_byte, r_feature[7:0]};
                    n_phase   = ST_CMD;
                end
                ST_CMD: begin
                    n_command = i_rx_byte;
                    n_phase   = ST_MODE;
                end
                ST_MODE: begin
                    n_mode     = i_rx_byte;
                    n_checksum = 32'd0;
                    if (r_length != 12'd0) begin
                        n_data_pos = 11'd0;
                        n_phase    = ST_DATA;
                    end else if (i_rx_byte[0]) begin
                        n_phase = ST_CRC0;
                    end else begin
                        n_phase     = ST_SYNC1;
                        o_res_valid = 1'b1;
                        res_done    = 1'b1;
                    end
                end
                ST_DATA: begin
                    n_data_pos  = pos_plus[10:0];
                    o_res_valid = 1'b1;
                    res_byte    = i_rx_byte;
                    res_index   = r_data_pos;
                    if (pos_plus >= r_length) begin
                        if (r_mode[0]) begin
                            n_phase = ST_CRC0;
                        end else begin
                            n_phase  = ST_SYNC1;
                            res_done = 1'b1;
                        end
                    end
                end
                ST_CRC0: begin
                    n_checksum = {24'd0, i_rx_byte};
                    n_phase    = ST_CRC1;
                end
                ST_CRC1: begin
                    n_checksum = r_checksum | {16'd0, i_rx_byte, 8'd0};
                    n_phase    = ST_CRC2;
                end
                ST_CRC2: begin
                    n_checksum = r_checksum | {8'd0, i_rx_byte, 16'd0};
                    n_phase    = ST_CRC3;
                end
                ST_CRC3: begin
                    n_checksum  = r_checksum | {i_rx_byte, 24'd0};
                    n_phase     = ST_SYNC1;
                    o_res_valid = 1'b1;
                    res_done    = 1'b1;
                end
                default: begin
                    n_phase = ST_SYNC1;
                end
            endcase
        end
    end

    // frame-complete results carry the header as updated by this byte
    always_comb begin
        o_res               = '0;
        o_res.payload_byte  = res_byte;
        o_res.payload_index = res_index;
        if (res_done) begin
            o_res.kind            = KIND_DONE;
            o_res.sender_id       = n_sender;
            o_res.length_field    = n_length;
            o_res.frame_serial    = n_serial;
            o_res.feature_address = n_feature;
            o_res.command_code    = n_command;
            o_res.mode_byte       = n_mode;
            o_res.checksum_value  = n_checksum;
            o_res.version_too_old = n_flags[0];
            o_res.lost_packets    = n_flags[1];
        end else begin
            o_res.kind = KIND_PAYLOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ST_SYNC1;
            r_sender   <= 16'd0;
            r_length   <= 12'd0;
            r_serial   <= 8'd0;
            r_feature  <= 16'd0;
            r_command  <= 8'd0;
            r_mode     <= 8'd0;
            r_data_pos <= 11'd0;
            r_checksum <= 32'd0;
            r_flags    <= 2'b00;
            r_prev_ser <= 8'd0;
            r_first    <= 1'b1;
        end else begin
            r_phase    <= n_phase;
            r_sender   <= n_sender;
            r_length   <= n_length;
            r_serial   <= n_serial;
            r_feature  <= n_feature;
            r_command  <= n_command;
            r_mode     <= n_mode;
            r_data_pos <= n_data_pos;
            r_checksum <= n_checksum;
            r_flags    <= n_flags;
            r_prev_ser <= n_prev_ser;
            r_first    <= n_first;
        end
    end

endmodule

// ===== rtl/shfp_out_buf.sv =====
// ----------------------------------------------------------------------------
// shfp_out_buf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
module shfp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  shfp_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output shfp_pkg::t_result o_data
);
    import shfp_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop     = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                // push is blocked while the skid entry is full
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_main = i_data;
            end else begin
                n_main_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

// ===== rtl/shfp_checker.sv =====
// ----------------------------------------------------------------------------
// shfp_port_checks
// port-level checks for the sync header frame parser, bound to the top level
// ----------------------------------------------------------------------------
module shfp_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_cmd,
    input logic [7:0]  i_rx_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_kind,
    input logic [7:0]  o_payload_byte,
    input logic [10:0] o_payload_index,
    input logic [15:0] o_sender_id,
    input logic [11:0] o_length_field,
    input logic [7:0]  o_frame_serial,
    input logic [15:0] o_feature_address,
    input logic [7:0]  o_command_code,
    input logic [7:0]  o_mode_byte,
    input logic [31:0] o_checksum_value,
    input logic        o_version_too_old,
    input logic        o_lost_packets,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    import shfp_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_payload_byte)
            && $stable(o_kind) && $stable(o_payload_index) && $stable(o_checksum_value))
        else $error("result changed while stalled");

    // payload results carry no sender id, length, checksum or flags
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_PAYLOAD |-> o_sender_id == 16'd0
            && o_length_field == 12'd0 && o_checksum_value == 32'd0
            && !o_version_too_old && !o_lost_packets)
        else $error("payload result with header fields set");

    // without the checksum mode bit the reported checksum is zero
    a_no_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DONE && !o_mode_byte[0] |-> o_checksum_value == 32'd0)
        else $error("checksum reported without mode bit");

    // a completed frame never declares more than the maximum payload
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DONE |-> o_length_field <= MAX_PAYLOAD)
        else $error("frame length above maximum");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind sync_header_frame_parser_top shfp_port_checks u_shfp_port_checks (.*);

// ===== sim/shfp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_checker
// watches the byte, result and register ports of the frame parser, keeps a
// model of the parse state and compares each returned result in order
// ----------------------------------------------------------------------------
module shfp_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_cmd,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  shfp_pkg::t_result i_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                o_fail_count,
    output int                o_pending
);
    import shfp_pkg::*;

    logic [15:0] min_version;
    logic [11:0] size_limit;

    t_phase      phase;
    logic [15:0] sender;
    logic [11:0] length;
    logic [7:0]  serial;
    logic [15:0] feature;
    logic [7:0]  command;
    logic [7:0]  mode;
    logic [10:0] position;
    logic [31:0] checksum;
    logic        too_old;
    logic        lost;
    logic [7:0]  prev_ser;
    logic        fresh_start;

    t_result     awaited_results[$];
    int          fails = 0;

    function automatic t_result done_result(input logic [7:0] pbyte, input logic [10:0] pidx);
        t_result r;
        r                 = '0;
        r.kind            = KIND_DONE;
        r.payload_byte    = pbyte;
        r.payload_index   = pidx;
        r.sender_id       = sender;
        r.length_field    = length;
        r.frame_serial    = serial;
        r.feature_address = feature;
        r.command_code    = command;
        r.mode_byte       = mode;
        r.checksum_value  = checksum;
        r.version_too_old = too_old;
        r.lost_packets    = lost;
        return r;
    endfunction

    task automatic advance_parser(input logic cmd, input logic [7:0] b);
        logic [15:0] declared;
        logic [11:0] cap;
        logic [11:0] next_pos;
        logic [8:0]  succ;
        t_result     r;
        r = '0;
        if (cmd == CMD_REARM) begin
            fresh_start = 1'b1;
            return;
        end
        case (phase)
            ST_SYNC1: begin
                too_old = 1'b0;
                lost    = 1'b0;
                if (b == SYNC_FIRST) phase = ST_SYNC2;
            end
            // a bad second sync byte is not retried as a first one
            ST_SYNC2: phase = (b == SYNC_SECOND) ? ST_SND_LO : ST_SYNC1;
            ST_SND_LO: begin
                sender = {8'h00, b};
                phase  = ST_SND_HI;
            end
            ST_SND_HI: begin
                sender = {b, sender[7:0]};
                if (sender < min_version) too_old = 1'b1;
                phase = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                length = {4'h0, b};
                phase  = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                declared = {b, length[7:0]};
                cap      = (size_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : size_limit;
                if (declared > {4'h0, cap}) begin
                    phase = ST_SYNC1;
                end else begin
                    length = declared[11:0];
                    phase  = ST_SERIAL;
                end
            end
            ST_SERIAL: begin
                serial = b;
                succ   = ({1'b0, prev_ser} + 9'd1) % {1'b0, SERIAL_MOD};
                if (fresh_start) fresh_start = 1'b0;
                else if (b != succ[7:0]) lost = 1'b1;
                prev_ser = b;
                phase    = ST_FEAT_LO;
            end
            ST_FEAT_LO: begin
                feature = {8'h00, b};
                phase   = ST_FEAT_HI;
            end
            ST_FEAT_HI: begin
                feature = {b, feature[7:0]};
                phase   = ST_CMD;
            end
            ST_CMD: begin
                command = b;
                phase   = ST_MODE;
            end
            ST_MODE: begin
                mode     = b;
                checksum = '0;
                if (length != 0) begin
                    position = '0;
                    phase    = ST_DATA;
                end else if (b[0]) begin
                    phase = ST_CRC0;
                end else begin
                    phase = ST_SYNC1;
                    awaited_results.push_back(done_result(8'h00, 11'd0));
                end
            end
            ST_DATA: begin
                next_pos = {1'b0, position} + 12'd1;
                if (next_pos >= length && !mode[0]) begin
                    // last byte closes the frame and rides in the done result
                    phase = ST_SYNC1;
                    awaited_results.push_back(done_result(b, position));
                end else begin
                    if (next_pos >= length) phase = ST_CRC0;
                    r.kind          = KIND_PAYLOAD;
                    r.payload_byte  = b;
                    r.payload_index = position;
                    awaited_results.push_back(r);
                end
                position = next_pos[10:0];
            end
            ST_CRC0: begin
                checksum = {24'h0, b};
                phase    = ST_CRC1;
            end
            ST_CRC1: begin
                checksum[15:8] = b;
                phase          = ST_CRC2;
            end
            ST_CRC2: begin
                checksum[23:16] = b;
                phase           = ST_CRC3;
            end
            ST_CRC3: begin
                checksum[31:24] = b;
                phase           = ST_SYNC1;
                awaited_results.push_back(done_result(8'h00, 11'd0));
            end
            default: phase = ST_SYNC1;
        endcase
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            min_version = MIN_VER_RESET;
            size_limit  = LIMIT_RESET;
            phase       = ST_SYNC1;
            sender      = '0;
            length      = '0;
            serial      = '0;
            feature     = '0;
            command     = '0;
            mode        = '0;
            position    = '0;
            checksum    = '0;
            too_old     = 1'b0;
            lost        = 1'b0;
            prev_ser    = '0;
            fresh_start = 1'b1;
            awaited_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_LIMIT) size_limit = pwdata[11:0];
                else min_version = pwdata[15:0];
            end
            // results are registered before leaving, so compare before predicting
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected, kind %0d byte 0x%0h",
                             $time, i_result.kind, i_result.payload_byte);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_result.kind));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(i_result.payload_byte));
                    check_field("payload_index", 32'(want.payload_index),
                                32'(i_result.payload_index));
                    check_field("sender_id", 32'(want.sender_id),
                                32'(i_result.sender_id));
                    check_field("length_field", 32'(want.length_field),
                                32'(i_result.length_field));
                    check_field("frame_serial", 32'(want.frame_serial),
                                32'(i_result.frame_serial));
                    check_field("feature_address", 32'(want.feature_address),
                                32'(i_result.feature_address));
                    check_field("command_code", 32'(want.command_code),
                                32'(i_result.command_code));
                    check_field("mode_byte", 32'(want.mode_byte),
                                32'(i_result.mode_byte));
                    check_field("checksum_value", want.checksum_value,
                                i_result.checksum_value);
                    check_field("version_too_old", 32'(want.version_too_old),
                                32'(i_result.version_too_old));
                    check_field("lost_packets", 32'(want.lost_packets),
                                32'(i_result.lost_packets));
                end
            end
            if (i_in_valid && i_in_ready) advance_parser(i_cmd, i_rx_byte);
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
    end

endmodule

// ===== sim/tb_sync_header_frame_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_header_frame_parser_top
// drives framed byte streams, rearm requests and register writes into the
// frame parser with random gaps and output stalls; the checker judges results
// ----------------------------------------------------------------------------
module tb_sync_header_frame_parser_top;
    import shfp_pkg::*;

    localparam logic [2:0] ADDR_MIN_VER = {REG_MIN_VER, 2'b00};
    localparam logic [2:0] ADDR_LIMIT   = {REG_LIMIT, 2'b00};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_cmd       = CMD_BYTE;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'h0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_kind;
    logic [7:0]  o_payload_byte;
    logic [10:0] o_payload_index;
    logic [15:0] o_sender_id;
    logic [11:0] o_length_field;
    logic [7:0]  o_frame_serial;
    logic [15:0] o_feature_address;
    logic [7:0]  o_command_code;
    logic [7:0]  o_mode_byte;
    logic [31:0] o_checksum_value;
    logic        o_version_too_old;
    logic        o_lost_packets;
    logic [31:0] prdata;
    logic        pready;

    t_result     dut_result;
    int          fail_count;
    int          pending_count;

    int          burst_left  = 0;
    int          n_items     = 0;
    int          rearm_odds  = 0;
    logic [15:0] cur_min     = MIN_VER_RESET;
    logic [11:0] cur_limit   = LIMIT_RESET;
    logic [7:0]  next_serial = 8'h00;

    int          rx_cycle    = 0;
    int          rx_mode     = 0;
    int          stall_left  = 0;

    assign dut_result = {o_kind, o_payload_byte, o_payload_index, o_sender_id,
                         o_length_field, o_frame_serial, o_feature_address,
                         o_command_code, o_mode_byte, o_checksum_value,
                         o_version_too_old, o_lost_packets};

    sync_header_frame_parser_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_payload_byte    (o_payload_byte),
        .o_payload_index   (o_payload_index),
        .o_sender_id       (o_sender_id),
        .o_length_field    (o_length_field),
        .o_frame_serial    (o_frame_serial),
        .o_feature_address (o_feature_address),
        .o_command_code    (o_command_code),
        .o_mode_byte       (o_mode_byte),
        .o_checksum_value  (o_checksum_value),
        .o_version_too_old (o_version_too_old),
        .o_lost_packets    (o_lost_packets),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    shfp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_result     (dut_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver: always ready, coin flips, or long stalls, in a mode picked anew at random
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_out_ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 20);
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        endcase
    end

    task automatic send_req(input logic cmd, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        n_items++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        if (rearm_odds > 0 && $urandom_range(1, rearm_odds) == 1)
            send_req(CMD_REARM, 8'($urandom_range(0, 255)));
        send_req(CMD_BYTE, b);
    endtask

    // fill < 0 gives random payload and checksum bytes
    task automatic send_frame(input logic [15:0] snd, input logic [15:0] len,
                              input logic [7:0] ser, input logic [15:0] feat,
                              input logic [7:0] code, input logic [7:0] mode,
                              input int fill);
        int cap;
        cap = int'((cur_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : cur_limit);
        send_rx(SYNC_FIRST);
        send_rx(SYNC_SECOND);
        send_rx(snd[7:0]);
        send_rx(snd[15:8]);
        send_rx(len[7:0]);
        send_rx(len[15:8]);
        if (len <= cap) begin
            send_rx(ser);
            send_rx(feat[7:0]);
            send_rx(feat[15:8]);
            send_rx(code);
            send_rx(mode);
            repeat (len) send_rx(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
            if (mode[0])
                repeat (4) send_rx(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
            next_serial = {1'b0, ser[6:0] + 7'd1};
        end
    endtask

    task automatic random_action();
        int          pick;
        int          n;
        int          cap;
        logic [15:0] snd;
        logic [15:0] len;
        logic [7:0]  ser;
        pick = $urandom_range(0, 99);
        cap  = int'((cur_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : cur_limit);
        if (pick < 72) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = 16'($urandom_range(0, (cap < 8) ? cap : 8));
                6:       len = 16'((cap < 40) ? cap : 40);
                7:       len = 16'(cap + 1);
                8:       len = 16'($urandom_range(cap + 1, 65535));
                default: len = 16'd0;
            endcase
            case ($urandom_range(0, 9))
                7:       snd = cur_min - 16'd1;
                8:       snd = cur_min;
                9:       snd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default: snd = 16'($urandom_range(0, 65535));
            endcase
            ser = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : next_serial;
            send_frame(snd, len, ser, 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), -1);
        end else if (pick < 86) begin
            // broken or cut-short header
            send_rx(SYNC_FIRST);
            if ($urandom_range(0, 1)) send_rx(SYNC_SECOND);
            n = $urandom_range(0, 9);
            repeat (n) send_rx(8'($urandom_range(0, 255)));
        end else if (pick < 92) begin
            send_req(CMD_REARM, 8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) send_rx(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int count);
        int start;
        start = n_items;
        while (n_items - start < count) random_action();
    endtask

    // hold off until every predicted result has been returned
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_LIMIT) cur_limit = data[11:0];
        else cur_min = data[15:0];
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: rearm, zero-length frame from sender 0, bad second sync, frame with
        // all-ones sender, mode, payload and checksum and a serial that breaks the sequence
        send_req(CMD_REARM, 8'hFF);
        send_frame(16'h0000, 16'h0000, 8'h80, 16'hFFFF, 8'hFF, 8'h00, 0);
        send_req(CMD_BYTE, SYNC_FIRST);
        send_req(CMD_BYTE, SYNC_FIRST);
        send_req(CMD_BYTE, SYNC_SECOND);
        send_frame(16'hFFFF, 16'h0001, 8'hFF, 16'h0000, 8'h00, 8'hFF, 255);

        rearm_odds = 40;
        run_random(220);

        drain();
        write_reg(ADDR_MIN_VER, 32'd0);
        write_reg(ADDR_LIMIT, 32'd0);
        run_random(140);

        // limit register above the maximum payload is clamped
        drain();
        write_reg(ADDR_MIN_VER, 32'hFFFF);
        write_reg(ADDR_LIMIT, 32'd4095);
        send_frame(16'($urandom_range(0, 65535)), 16'd40, next_serial,
                   16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), -1);
        run_random(180);

        drain();
        write_reg(ADDR_MIN_VER, 32'($urandom_range(2, 65534)));
        write_reg(ADDR_LIMIT, 32'($urandom_range(1, 40)));
        run_random(180);

        drain();
        write_reg(ADDR_MIN_VER, 32'd1);
        write_reg(ADDR_LIMIT, 32'd12);
        run_random(140);

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
